// ===== rtl/core/csort_pkg.sv =====
// ----------------------------------------------------------------------------
// csort_pkg
// Types shared by the counting sort front, back and top level, and the back's state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csort_pkg;

  localparam int KEY_W = 8;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    key_t key;
    logic last;
  } item_t;

  typedef struct packed {
    key_t key;
    logic last;
    logic ovf;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT,
    ST_WALK_RD,
    ST_WALK_CNT,
    ST_WALK_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/csort_ram.sv =====
// ----------------------------------------------------------------------------
// csort_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module csort_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/csort_front.sv =====
// ----------------------------------------------------------------------------
// csort_front
// Input side: accept keys, clamp them to the top key and queue them in a
// two-entry FIFO for the histogram engine.
// ----------------------------------------------------------------------------
`default_nettype none

module csort_front #(
  parameter int TOP_KEY = 255
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire csort_pkg::key_t  s_tdata,
  input  wire logic             s_tlast,
  output logic                  q_valid,
  output csort_pkg::item_t      q_item,
  input  wire logic             q_pop
);

  localparam csort_pkg::key_t TOP_K = csort_pkg::key_t'(TOP_KEY);

  csort_pkg::item_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;
  csort_pkg::item_t in_item;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr];

  always_comb begin
    in_item.key  = (s_tdata > TOP_K) ? TOP_K : s_tdata;
    in_item.last = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/csort_back.sv =====
// ----------------------------------------------------------------------------
// csort_back
// Histogram engine: count queued keys, up to the batch limit, into the histogram
// RAM, then walk it upward on the last key, emit the sorted batch and zero each entry it reads.
// ----------------------------------------------------------------------------
`default_nettype none

module csort_back #(
  parameter int TOP_KEY   = 255,
  parameter int MAX_ITEMS = 64,
  parameter int DEPTH     = 256,
  parameter int AW        = 8,
  parameter int CW        = 7
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire csort_pkg::item_t  q_item,
  output logic                   q_pop,
  input  wire logic              out_free,
  output logic                   res_push,
  output csort_pkg::result_t     res
);

  localparam logic [AW-1:0] TOP_A = AW'(TOP_KEY);
  localparam logic [CW-1:0] LIMIT = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE   = CW'(1);

  csort_pkg::state_t state;
  csort_pkg::state_t state_next;

  logic [AW-1:0] v;
  logic [AW-1:0] key_r;
  logic          last_r;
  logic [CW-1:0] batch_count;
  logic [CW-1:0] rem;
  logic          overflow_seen;

  logic          we;
  logic [AW-1:0] waddr;
  logic [CW-1:0] wdata;
  logic [AW-1:0] raddr;
  logic [CW-1:0] rdata;
  logic [AW-1:0] v_inc;
  logic          fin;

  csort_ram #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign v_inc = (v == TOP_A) ? v : v + AW'(1);
  assign fin   = (batch_count == ONE);

  always_comb begin
    state_next = state;
    unique case (state)
      csort_pkg::ST_CLEAR: begin
        if (v == TOP_A) state_next = csort_pkg::ST_IDLE;
      end
      csort_pkg::ST_IDLE: begin
        if (q_valid) begin
          if (batch_count < LIMIT) state_next = csort_pkg::ST_COUNT;
          else if (q_item.last)    state_next = csort_pkg::ST_WALK_RD;
        end
      end
      csort_pkg::ST_COUNT: begin
        state_next = last_r ? csort_pkg::ST_WALK_RD : csort_pkg::ST_IDLE;
      end
      csort_pkg::ST_WALK_RD: begin
        state_next = csort_pkg::ST_WALK_CNT;
      end
      csort_pkg::ST_WALK_CNT: begin
        if (rdata != '0) state_next = csort_pkg::ST_WALK_EMIT;
      end
      csort_pkg::ST_WALK_EMIT: begin
        if (out_free) begin
          if (fin)             state_next = csort_pkg::ST_IDLE;
          else if (rem == ONE) state_next = csort_pkg::ST_WALK_CNT;
        end
      end
      default: state_next = csort_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    we       = 1'b0;
    waddr    = v;
    wdata    = '0;
    raddr    = v;
    res_push = 1'b0;
    unique case (state)
      csort_pkg::ST_CLEAR: begin
        we = 1'b1;
      end
      csort_pkg::ST_IDLE: begin
        q_pop = q_valid;
        raddr = q_item.key[AW-1:0];
      end
      csort_pkg::ST_COUNT: begin
        we    = 1'b1;
        waddr = key_r;
        wdata = rdata + ONE;
      end
      csort_pkg::ST_WALK_RD: begin
        raddr = v;
      end
      csort_pkg::ST_WALK_CNT: begin
        we    = 1'b1;
        raddr = v_inc;
      end
      csort_pkg::ST_WALK_EMIT: begin
        raddr    = v_inc;
        res_push = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    res.key  = csort_pkg::key_t'(v);
    res.last = fin;
    res.ovf  = fin && overflow_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csort_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v             <= '0;
      batch_count   <= '0;
      overflow_seen <= 1'b0;
    end else begin
      unique case (state)
        csort_pkg::ST_CLEAR: begin
          v <= (v == TOP_A) ? '0 : v + AW'(1);
        end
        csort_pkg::ST_IDLE: begin
          if (q_valid && !(batch_count < LIMIT)) overflow_seen <= 1'b1;
        end
        csort_pkg::ST_COUNT: begin
          batch_count <= batch_count + ONE;
        end
        csort_pkg::ST_WALK_CNT: begin
          if (rdata == '0) v <= v_inc;
        end
        csort_pkg::ST_WALK_EMIT: begin
          if (out_free) begin
            batch_count <= batch_count - ONE;
            if (fin) begin
              v             <= '0;
              overflow_seen <= 1'b0;
            end else if (rem == ONE) begin
              v <= v_inc;
            end
          end
        end
        default: begin
          v <= v;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == csort_pkg::ST_IDLE && q_valid) begin
      key_r  <= q_item.key[AW-1:0];
      last_r <= q_item.last;
    end
    if (state == csort_pkg::ST_WALK_CNT) begin
      rem <= rdata;
    end else if (state == csort_pkg::ST_WALK_EMIT && out_free) begin
      rem <= rem - ONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/counting_sort_unit.sv =====
// ----------------------------------------------------------------------------
// counting_sort_unit
// Counting sort of a batch of small unsigned keys through a histogram RAM.
// ----------------------------------------------------------------------------
// Channel | Direction | tdata       | tlast     | tuser
// s_*     | in        | key[7:0]    | batch_end | -
// m_*     | out       | sorted_key  | is_last   | overflowed
//
// Each key is counted by a histogram read, then a write back of its count plus one.
// On the last key the walk reads the first entry, then visits histogram entries
// upward and emits each key as often as it was counted, holding while the output
// is not free, until the whole batch is out. After reset a clearing pass zeroes
// all top key+1 histogram entries before the first key is taken. A two-entry
// input FIFO and the output register let either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_sort_unit #(
  parameter int KEY_MAX   = 255,
  parameter int MAX_ITEMS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] key
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic      [7:0] m_tdata,   // [7:0] sorted_key
  output logic            m_tlast,
  output logic            m_tuser    // [0] overflowed
);

  localparam int TOP_KEY = (KEY_MAX > 255) ? 255 : KEY_MAX;
  localparam int DEPTH   = TOP_KEY + 1;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(MAX_ITEMS + 1);

  logic               q_valid;
  csort_pkg::item_t   q_item;
  logic               q_pop;
  logic               out_free;
  logic               res_push;
  csort_pkg::result_t res;

  csort_front #(
    .TOP_KEY (TOP_KEY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  csort_back #(
    .TOP_KEY   (TOP_KEY),
    .MAX_ITEMS (MAX_ITEMS),
    .DEPTH     (DEPTH),
    .AW        (AW),
    .CW        (CW)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_free (out_free),
    .res_push (res_push),
    .res      (res)
  );

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_push;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      m_tdata <= res.key;
      m_tlast <= res.last;
      m_tuser <= res.ovf;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Batches of 8-bit keys are streamed into counting_sort_unit. A histogram
// model in the bench predicts the sorted output, including dropped keys on
// full batches, and checks every result transaction against the oldest
// prediction. Both sides idle at random outside a calm window. The receiver
// also holds off for a long stretch, and the sender drains before two batches.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int KEY_TOP   = 255;
  localparam int BATCH_CAP = 64;
  localparam int HOLD_LEN  = 400;
  localparam int SETTLE    = 2 * (KEY_TOP + 1) + BATCH_CAP + 100;
  localparam int ITEM_GOAL = 450;

  typedef struct {
    csort_pkg::item_t it;
    bit               drain;
    bit               kick;
  } pend_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'd0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  pend_t              pending_q[$];
  pend_t              cur_item;
  csort_pkg::result_t sorted_expect_q[$];
  int      pushed_cnt = 0;
  int      seen_cnt = 0;
  int      err_cnt = 0;
  int      cycle_no = 0;
  int      hold_left = 0;
  logic    hold_kick = 1'b0;
  logic    calm;

  logic [6:0] key_tally [0:255];
  logic [6:0] tally_items;
  logic       tally_dropped;

  assign calm = (cycle_no >= 6000) && (cycle_no < 12000);

  counting_sort_unit #(
    .KEY_MAX   (KEY_TOP),
    .MAX_ITEMS (BATCH_CAP)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] key
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [7:0] sorted_key
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)    // [0] overflowed
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
  end

  // Count one key into the histogram unless the batch is full; on batch end, emit the sorted batch.
  function automatic int count_key(csort_pkg::item_t it);
    int   k;
    int   total;
    int   emitted;
    csort_pkg::result_t r;
    k = (int'(it.key) > KEY_TOP) ? KEY_TOP : int'(it.key);
    if (int'(tally_items) < BATCH_CAP) begin
      key_tally[k] = key_tally[k] + 7'd1;
      tally_items = tally_items + 7'd1;
    end else begin
      tally_dropped = 1'b1;
    end
    if (!it.last) return 0;
    total = int'(tally_items);
    emitted = 0;
    for (int v = 0; v <= KEY_TOP; v++) begin
      for (int c = 0; c < int'(key_tally[v]); c++) begin
        if (emitted < total) begin
          r.key  = csort_pkg::key_t'(v);
          r.last = (emitted + 1 == total);
          r.ovf  = (emitted + 1 == total) && tally_dropped;
          sorted_expect_q.push_back(r);
          emitted++;
        end
      end
    end
    for (int v = 0; v < 256; v++) key_tally[v] = 7'd0;
    tally_items = 7'd0;
    tally_dropped = 1'b0;
    return emitted;
  endfunction

  always @(posedge clk) begin : drv
    int   n;
    bit   busy;
    bit   go;
    logic kick_v;
    if (rst) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= 8'd0;
      s_tlast   <= 1'b0;
      hold_kick <= 1'b0;
    end else begin
      n = 0;
      kick_v = 1'b0;
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        n = count_key(cur_item.it);
        kick_v = cur_item.kick;
        busy = 1'b0;
      end
      pushed_cnt <= pushed_cnt + n;
      if (!busy) begin
        go = 1'b0;
        if (pending_q.size() != 0) begin
          if (pending_q[0].drain) go = (pushed_cnt + n == seen_cnt);
          else go = calm || ($urandom_range(99) >= 13);
        end
        if (go) begin
          cur_item = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_item.it.key;
          s_tlast  <= cur_item.it.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      hold_kick <= kick_v;
    end
  end

  // Hold off the receiver for a long stretch when kicked.
  always @(posedge clk) begin
    if (rst) hold_left <= 0;
    else if (hold_kick) hold_left <= HOLD_LEN;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin : mon
    csort_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (seen_cnt >= pushed_cnt) begin
          $error("unexpected result: sorted_key %0d is_last %0b overflowed %0b",
                 m_tdata, m_tlast, m_tuser);
          err_cnt++;
        end else begin
          want = sorted_expect_q.pop_front();
          seen_cnt <= seen_cnt + 1;
          if (m_tdata !== want.key) begin
            $error("sorted_key: expected %0d, got %0d", want.key, m_tdata);
            err_cnt++;
          end
          if (m_tlast !== want.last) begin
            $error("is_last: expected %0b, got %0b", want.last, m_tlast);
            err_cnt++;
          end
          if (m_tuser !== want.ovf) begin
            $error("overflowed: expected %0b, got %0b", want.ovf, m_tuser);
            err_cnt++;
          end
        end
      end
      m_tready <= (hold_left == 0) && (calm || ($urandom_range(99) >= 13));
    end
  end

  task automatic queue_key(int k, bit last, bit drain, bit kick);
    pend_t p;
    p.it.key  = csort_pkg::key_t'(k);
    p.it.last = last;
    p.drain   = drain;
    p.kick    = kick;
    pending_q.push_back(p);
  endtask

  task automatic queue_batch(int n, bit drain, bit kick);
    int style;
    int base;
    int k;
    style = $urandom_range(2);
    base = $urandom_range(255);
    for (int i = 0; i < n; i++) begin
      case (style)
        0: k = $urandom_range(255);
        1: begin
          k = base + $urandom_range(3);
          if (k > 255) k = 255;
        end
        default: k = ($urandom_range(1) != 0) ? 255 : $urandom_range(1) * 0;
      endcase
      queue_key(k, i == n - 1, drain && i == 0, kick && i == 0);
    end
  endtask

  initial begin : stim
    int added;
    int sz;
    int r;
    for (int v = 0; v < 256; v++) key_tally[v] = 7'd0;
    tally_items = 7'd0;
    tally_dropped = 1'b0;

    // single-key batches at both extremes
    queue_key(0, 1'b1, 1'b0, 1'b0);
    queue_key(255, 1'b1, 1'b0, 1'b0);
    // mixed extremes with duplicates, reversed order
    queue_key(255, 1'b0, 1'b0, 1'b0);
    queue_key(0, 1'b0, 1'b0, 1'b0);
    queue_key(128, 1'b0, 1'b0, 1'b0);
    queue_key(0, 1'b0, 1'b0, 1'b0);
    queue_key(1, 1'b0, 1'b0, 1'b0);
    queue_key(254, 1'b1, 1'b0, 1'b0);
    // all keys equal except one
    queue_key(170, 1'b0, 1'b0, 1'b0);
    queue_key(170, 1'b0, 1'b0, 1'b0);
    queue_key(170, 1'b0, 1'b0, 1'b0);
    queue_key(85, 1'b1, 1'b0, 1'b0);
    // stall the receiver while short batches pile up behind it
    for (int b = 0; b < 5; b++) queue_batch(3, b == 0, b == 0);
    added = 27;

    // full batch, then an overflowing one, then random sizes
    sz = 64;
    queue_batch(sz, 1'b1, 1'b0);
    added += sz;
    sz = 68;
    queue_batch(sz, 1'b0, 1'b0);
    added += sz;
    while (added < ITEM_GOAL) begin
      r = $urandom_range(99);
      if (r < 60) sz = $urandom_range(6, 1);
      else if (r < 85) sz = $urandom_range(30, 7);
      else if (r < 95) sz = $urandom_range(64, 31);
      else sz = $urandom_range(72, 65);
      queue_batch(sz, 1'b0, 1'b0);
      added += sz;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || s_tvalid) @(posedge clk);
    while (seen_cnt != pushed_cnt) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
